>>> rtl/tmrb_pkg.sv
package tmrb_pkg;

  // Bank size and field widths
  localparam int unsigned TimerCount = 8;
  localparam int unsigned AddrW      = (TimerCount > 1) ? $clog2(TimerCount) : 1;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned OpW        = 3;
  localparam int unsigned KindW      = 2;
  localparam int unsigned StW        = 3;
  localparam int unsigned DataW      = 32;

  // Opcodes
  localparam logic [OpW-1:0] OP_TICK    = 3'd0;
  localparam logic [OpW-1:0] OP_INIT    = 3'd1;
  localparam logic [OpW-1:0] OP_START   = 3'd2;
  localparam logic [OpW-1:0] OP_STOP    = 3'd3;
  localparam logic [OpW-1:0] OP_DESTROY = 3'd4;
  localparam logic [OpW-1:0] OP_QUERY   = 3'd5;

  // Timer life states
  localparam logic [StW-1:0] ST_UNUSED    = 3'd0;
  localparam logic [StW-1:0] ST_CREATED   = 3'd1;
  localparam logic [StW-1:0] ST_STARTED   = 3'd2;
  localparam logic [StW-1:0] ST_STOPPED   = 3'd3;
  localparam logic [StW-1:0] ST_DESTROYED = 3'd4;

  // Result kinds
  localparam logic [KindW-1:0] K_FIRED  = 2'd0;
  localparam logic [KindW-1:0] K_QUERY  = 2'd1;
  localparam logic [KindW-1:0] K_ACCEPT = 2'd2;
  localparam logic [KindW-1:0] K_IGNORE = 2'd3;

  // One timer as stored in the state memory
  typedef struct packed {
    logic [StW-1:0]   life;
    logic             hard;
    logic [DataW-1:0] cnt;
    logic [DataW-1:0] delay;
    logic [DataW-1:0] reload;
  } ent_t;

  localparam int unsigned EntW = $bits(ent_t);

  // One result
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdxW-1:0]  which;
    logic [StW-1:0]   life;
    logic [DataW-1:0] remaining;
    logic [DataW-1:0] delay;
    logic             cls;
    logic             last;
  } res_t;

endpackage

>>> rtl/tmrb_ram.sv
module tmrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                                          clk_i,
  input  logic                                          wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  wr_addr_i,
  input  logic [Width-1:0]                              wr_data_i,
  input  logic                                          rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  rd_addr_i,
  output logic [Width-1:0]                              rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/one_shot_periodic_timer_bank.sv
// Bank of eight timers, each with a start delay, a reload period, a remaining count, a
// hard/soft class and a life state, all kept in one single-port-read state memory.
// Every request carries one opcode. A command (init, start, stop, destroy, query, or an
// unknown opcode) first reads the timer's entry in the accept cycle; S_CMD then, once the
// output register is free, updates it and writes the one result into the output register.
// A tick scans the bank: the memory read port visits one timer per cycle while the scan is
// not held for the output, first over all hard timers and then over all soft ones, each in
// index order, and a final S_FLUSH state hands over the last fired result. A tick emits one
// result per timer that fired, possibly none; the last result of any request has last_o set.
// Results sit in an output register, so a new request is taken while a result still
// waits; the sequencer only holds when it must hand over a result and the output side
// is stalling. Timer entries never written read as zero through per-entry valid bits.
module one_shot_periodic_timer_bank (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tmrb_pkg::OpW-1:0]     opcode_i,
  input  logic [tmrb_pkg::IdxW-1:0]    timer_index_i,
  input  logic [tmrb_pkg::DataW-1:0]   start_delay_i,
  input  logic [tmrb_pkg::DataW-1:0]   period_i,
  input  logic                         hard_class_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tmrb_pkg::KindW-1:0]   kind_o,
  output logic [tmrb_pkg::IdxW-1:0]    which_timer_o,
  output logic [tmrb_pkg::StW-1:0]     life_state_o,
  output logic [tmrb_pkg::DataW-1:0]   remaining_o,
  output logic [tmrb_pkg::DataW-1:0]   delay_out_o,
  output logic                         class_out_o,
  output logic                         last_o
);

  import tmrb_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMD   = 2'd1;
  localparam logic [1:0] S_TICK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]            state_q, state_d;

  // Captured request
  logic [OpW-1:0]        op_q;
  logic [IdxW-1:0]       idx_q;
  logic [DataW-1:0]      dly_q;
  logic [DataW-1:0]      per_q;
  logic                  hard_q;

  // Tick scan position: timer index and class being served
  logic [AddrW-1:0]      scan_idx_q, scan_idx_d;
  logic                  cls_q, cls_d;

  // Entry written at least once since reset
  logic [TimerCount-1:0] vld_q;

  // Fired result held back until it is known whether it is the last one
  logic                  pend_vld_q, pend_vld_d;
  res_t                  pend_q, pend_d;

  // Output register
  logic                  out_vld_q;
  res_t                  out_q, out_d;
  logic                  out_load;
  logic                  out_free;

  // State memory port
  logic                  rd_en;
  logic [AddrW-1:0]      rd_addr;
  logic [EntW-1:0]       rd_data;
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  ent_t                  wr_data;

  logic [AddrW-1:0]      exe_addr;
  ent_t                  cur_ent;

  // Command datapath
  logic                  idx_ok;
  logic                  cmd_wr;
  logic [KindW-1:0]      cmd_kind;
  ent_t                  cmd_ent;
  res_t                  cmd_res;

  // Tick datapath
  logic                  active;
  logic                  fire;
  ent_t                  tick_ent;
  res_t                  tick_res;
  logic                  go;
  logic                  scan_end;

  tmrb_ram #(
    .Width (EntW),
    .Depth (TimerCount)
  ) u_state_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Take a new request only when the sequencer is free
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_vld_q || !out_stall_i;

  // The entry under work: the command's timer, or the current scan position.
  // Read data is held by the memory until the next read, so a stall keeps it.
  assign exe_addr = (state_q == S_CMD) ? idx_q[AddrW-1:0] : scan_idx_q;
  assign cur_ent  = vld_q[exe_addr] ? ent_t'(rd_data) : '0;

  // Command: decide the update and the single result
  assign idx_ok = (int'(idx_q) < TimerCount);

  always_comb begin
    cmd_ent  = cur_ent;
    cmd_kind = K_IGNORE;
    cmd_wr   = 1'b0;
    if (idx_ok) begin
      unique case (op_q)
        OP_INIT: begin
          cmd_ent.delay  = dly_q;
          cmd_ent.reload = per_q;
          cmd_ent.hard   = hard_q;
          cmd_ent.cnt    = (dly_q != '0) ? dly_q : per_q;
          cmd_ent.life   = ST_CREATED;
          cmd_kind       = K_ACCEPT;
          cmd_wr         = 1'b1;
        end
        OP_START: begin
          if (cur_ent.life == ST_CREATED || cur_ent.life == ST_STOPPED) begin
            cmd_ent.cnt  = (cur_ent.delay != '0) ? cur_ent.delay : cur_ent.reload;
            cmd_ent.life = ST_STARTED;
            cmd_kind     = K_ACCEPT;
            cmd_wr       = 1'b1;
          end
        end
        OP_STOP: begin
          if (cur_ent.life == ST_STARTED) begin
            cmd_ent.life = ST_STOPPED;
            cmd_kind     = K_ACCEPT;
            cmd_wr       = 1'b1;
          end
        end
        OP_DESTROY: begin
          cmd_ent.life = ST_DESTROYED;
          cmd_kind     = K_ACCEPT;
          cmd_wr       = 1'b1;
        end
        OP_QUERY: begin
          cmd_kind = K_QUERY;
        end
        default: begin
          // unknown opcode: report the timer, change nothing
          cmd_kind = K_IGNORE;
        end
      endcase
    end

    cmd_res       = '0;
    cmd_res.kind  = cmd_kind;
    cmd_res.which = idx_q;
    cmd_res.last  = 1'b1;
    if (idx_ok) begin
      cmd_res.life      = cmd_ent.life;
      cmd_res.remaining = cmd_ent.cnt;
      cmd_res.delay     = cmd_ent.delay;
      cmd_res.cls       = cmd_ent.hard;
    end
  end

  // Tick: count down one started timer of the class being served
  always_comb begin
    active   = (cur_ent.life == ST_STARTED) && (cur_ent.hard == cls_q);
    fire     = active && (cur_ent.cnt <= DataW'(1));
    tick_ent = cur_ent;
    if (fire) begin
      if (cur_ent.reload != '0) begin
        tick_ent.cnt = cur_ent.reload;
      end else begin
        tick_ent.cnt  = '0;
        tick_ent.life = ST_STOPPED;
      end
    end else begin
      tick_ent.cnt = cur_ent.cnt - DataW'(1);
    end

    tick_res           = '0;
    tick_res.kind      = K_FIRED;
    tick_res.which     = IdxW'(scan_idx_q);
    tick_res.life      = tick_ent.life;
    tick_res.remaining = tick_ent.cnt;
    tick_res.delay     = tick_ent.delay;
    tick_res.cls       = tick_ent.hard;
  end

  assign scan_end = (scan_idx_q == AddrW'(TimerCount - 1));
  // A second fire pushes the held one out, which needs room at the output
  assign go       = !(fire && pend_vld_q) || out_free;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    cls_d      = cls_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_load   = 1'b0;
    out_d      = out_q;
    rd_en      = 1'b0;
    rd_addr    = exe_addr;
    wr_en      = 1'b0;
    wr_addr    = exe_addr;
    wr_data    = cur_ent;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rd_en = 1'b1;
          if (opcode_i == OP_TICK) begin
            rd_addr    = '0;
            scan_idx_d = '0;
            cls_d      = 1'b1;
            state_d    = S_TICK;
          end else begin
            rd_addr = timer_index_i[AddrW-1:0];
            state_d = S_CMD;
          end
        end
      end

      S_CMD: begin
        // hold until the output register can take the result
        if (out_free) begin
          out_load = 1'b1;
          out_d    = cmd_res;
          wr_en    = cmd_wr;
          wr_data  = cmd_ent;
          state_d  = S_IDLE;
        end
      end

      S_TICK: begin
        if (go) begin
          wr_en   = active;
          wr_data = tick_ent;
          if (fire) begin
            pend_d     = tick_res;
            pend_vld_d = 1'b1;
            if (pend_vld_q) begin
              out_load = 1'b1;
              out_d    = pend_q;
            end
          end
          // advance the scan: next index, then the soft class, then flush
          if (!scan_end) begin
            scan_idx_d = scan_idx_q + AddrW'(1);
            rd_en      = 1'b1;
            rd_addr    = scan_idx_q + AddrW'(1);
          end else if (cls_q) begin
            cls_d      = 1'b0;
            scan_idx_d = '0;
            rd_en      = 1'b1;
            rd_addr    = '0;
          end else begin
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_d      = pend_q;
          out_d.last = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_idx_q <= '0;
      cls_q      <= 1'b0;
      vld_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      cls_q      <= cls_d;
      pend_vld_q <= pend_vld_d;
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q   <= opcode_i;
      idx_q  <= timer_index_i;
      dly_q  <= start_delay_i;
      per_q  <= period_i;
      hard_q <= hard_class_i;
    end
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign kind_o        = out_q.kind;
  assign which_timer_o = out_q.which;
  assign life_state_o  = out_q.life;
  assign remaining_o   = out_q.remaining;
  assign delay_out_o   = out_q.delay;
  assign class_out_o   = out_q.cls;
  assign last_o        = out_q.last;

`ifndef SYNTHESIS
  // No fired result may be left behind once the sequencer is free again
  a_pend_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_vld_q)
    else $error("held fired result left over in idle");

  // The memory is never written from idle
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q != S_IDLE))
    else $error("state memory written while idle");

  // Read and write in the same cycle never touch the same timer
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of the same timer in one cycle");

  // An accepted command is executed in the following cycle's state
  a_cmd_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && opcode_i != OP_TICK) |=> (state_q == S_CMD))
    else $error("accepted command did not enter execution");
`endif

endmodule

>>> bench/one_shot_periodic_timer_bank_test.sv
module one_shot_periodic_timer_bank_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tmrb_pkg::*;

  // Opcodes outside the defined set; the block must answer them as ignored
  localparam logic [OpW-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OpW-1:0] OP_RSVD7 = 3'd7;

  // A tick reports at most this many expiries
  localparam int unsigned MaxFired = 8;

  // Sequencing limits for the run
  localparam int unsigned RequestTotal = 410;
  localparam int unsigned CalmFrom     = 340;
  localparam int unsigned LongHoldAt   = 40;
  localparam int unsigned LongHoldLen  = 400;
  localparam int unsigned DrainCycles  = 40;

  // One row of the directed table; want is used only when typed is set
  typedef struct {
    logic [OpW-1:0]   op;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] dly;
    logic [DataW-1:0] per;
    logic             hard;
    bit               typed;
    res_t             want;
  } step_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OpW-1:0]      opcode_i;
  logic [IdxW-1:0]     timer_index_i;
  logic [DataW-1:0]    start_delay_i;
  logic [DataW-1:0]    period_i;
  logic                hard_class_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [KindW-1:0]    kind_o;
  logic [IdxW-1:0]     which_timer_o;
  logic [StW-1:0]      life_state_o;
  logic [DataW-1:0]    remaining_o;
  logic [DataW-1:0]    delay_out_o;
  logic                class_out_o;
  logic                last_o;

  res_t                result_bus;

  // Shadow copy of the timer bank
  logic [DataW-1:0]    tmr_count  [TimerCount];
  logic [DataW-1:0]    tmr_delay  [TimerCount];
  logic [DataW-1:0]    tmr_period [TimerCount];
  logic [StW-1:0]      tmr_life   [TimerCount];
  logic                tmr_hard   [TimerCount];

  res_t                step_results[$];    // results of the request just predicted
  res_t                awaited_results[$]; // results still owed by the block
  step_row_t           directed_steps[$];

  int unsigned         requests_sent;
  int unsigned         results_seen;
  int unsigned         mismatch_count;
  bit                  calm_tail;

  one_shot_periodic_timer_bank uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .timer_index_i (timer_index_i),
    .start_delay_i (start_delay_i),
    .period_i      (period_i),
    .hard_class_i  (hard_class_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .which_timer_o (which_timer_o),
    .life_state_o  (life_state_o),
    .remaining_o   (remaining_o),
    .delay_out_o   (delay_out_o),
    .class_out_o   (class_out_o),
    .last_o        (last_o)
  );

  assign result_bus = {kind_o, which_timer_o, life_state_o, remaining_o,
                       delay_out_o, class_out_o, last_o};

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Timer bank predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_timer_bank();
    for (int i = 0; i < TimerCount; i++) begin
      tmr_count[i]  = '0;
      tmr_delay[i]  = '0;
      tmr_period[i] = '0;
      tmr_life[i]   = ST_UNUSED;
      tmr_hard[i]   = 1'b0;
    end
  endfunction

  // Capture the stored view of one timer as a result
  function automatic res_t snapshot(logic [KindW-1:0] k, int unsigned t);
    res_t r;
    r.kind      = k;
    r.which     = IdxW'(t);
    r.life      = tmr_life[t];
    r.remaining = tmr_count[t];
    r.delay     = tmr_delay[t];
    r.cls       = tmr_hard[t];
    r.last      = 1'b0;
    return r;
  endfunction

  // Initial count: the start delay, or the period when the delay is zero
  function automatic logic [DataW-1:0] first_count(int unsigned t);
    return (tmr_delay[t] != '0) ? tmr_delay[t] : tmr_period[t];
  endfunction

  // Advance the shadow bank by one request and collect the results it causes
  task automatic apply_request(input step_row_t r);
    logic [KindW-1:0] k;
    res_t             res;
    bit               fire;
    int unsigned      t;
    t = 32'(r.idx);
    step_results.delete();
    if (r.op == OP_TICK) begin
      // Serve hard timers first, then soft ones, each group in index order
      for (int g = 0; g < 2; g++) begin
        for (int i = 0; i < TimerCount; i++) begin
          if (tmr_life[i] == ST_STARTED && tmr_hard[i] == (g == 0)) begin
            // A started timer already at zero fires at once
            if (tmr_count[i] != '0) begin
              tmr_count[i] = tmr_count[i] - DataW'(1);
              fire = (tmr_count[i] == '0);
            end else begin
              fire = 1'b1;
            end
            if (fire) begin
              if (tmr_period[i] != '0) begin
                tmr_count[i] = tmr_period[i];
              end else begin
                tmr_count[i] = '0;
                tmr_life[i]  = ST_STOPPED;
              end
              if (step_results.size() < MaxFired) begin
                step_results.push_back(snapshot(K_FIRED, i));
              end
            end
          end
        end
      end
      if (step_results.size() != 0) begin
        step_results[step_results.size() - 1].last = 1'b1;
      end
    end else begin
      k = K_IGNORE;
      case (r.op)
        OP_INIT: begin
          tmr_delay[t]  = r.dly;
          tmr_period[t] = r.per;
          tmr_hard[t]   = r.hard;
          tmr_count[t]  = first_count(t);
          tmr_life[t]   = ST_CREATED;
          k = K_ACCEPT;
        end
        OP_START: begin
          if (tmr_life[t] == ST_CREATED || tmr_life[t] == ST_STOPPED) begin
            tmr_count[t] = first_count(t);
            tmr_life[t]  = ST_STARTED;
            k = K_ACCEPT;
          end
        end
        OP_STOP: begin
          if (tmr_life[t] == ST_STARTED) begin
            tmr_life[t] = ST_STOPPED;
            k = K_ACCEPT;
          end
        end
        OP_DESTROY: begin
          tmr_life[t] = ST_DESTROYED;
          k = K_ACCEPT;
        end
        OP_QUERY: begin
          k = K_QUERY;
        end
        default: begin
        end
      endcase
      res = snapshot(k, t);
      res.last = 1'b1;
      step_results.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request rows
  // ---------------------------------------------------------------------------

  function automatic step_row_t cmd(logic [OpW-1:0] op, logic [IdxW-1:0] idx,
                                    logic [DataW-1:0] dly, logic [DataW-1:0] per,
                                    logic hard);
    step_row_t r;
    r.op    = op;
    r.idx   = idx;
    r.dly   = dly;
    r.per   = per;
    r.hard  = hard;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  // Row with its single result typed in: kind, life, remaining, stored delay, class
  function automatic step_row_t cmd_chk(logic [OpW-1:0] op, logic [IdxW-1:0] idx,
                                        logic [DataW-1:0] dly, logic [DataW-1:0] per,
                                        logic hard, logic [KindW-1:0] k,
                                        logic [StW-1:0] life, logic [DataW-1:0] rem,
                                        logic [DataW-1:0] dout, logic cls);
    step_row_t r;
    r = cmd(op, idx, dly, per, hard);
    r.typed = 1'b1;
    r.want  = {k, idx, life, rem, dout, cls, 1'b1};
    return r;
  endfunction

  // Counts lean small so that timers expire often; a few span the full width
  function automatic logic [DataW-1:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 4);
      6, 7:             return $urandom_range(0, 24);
      8:                return $urandom;
      default:          return 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until accepted, then record what it owes
  task automatic issue(input step_row_t r);
    // Insert an idle burst now and then, never in the tail
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    opcode_i      <= r.op;
    timer_index_i <= r.idx;
    start_delay_i <= r.dly;
    period_i      <= r.per;
    hard_class_i  <= r.hard;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_request(r);
    if (r.typed) begin
      awaited_results.push_back(r.want);
    end else begin
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    end
    requests_sent++;
    calm_tail = (requests_sent >= CalmFrom);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [IdxW-1:0] t;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    opcode_i      = OP_TICK;
    timer_index_i = '0;
    start_delay_i = '0;
    period_i      = '0;
    hard_class_i  = 1'b0;
    calm_tail     = 1'b0;
    requests_sent = 0;
    clear_timer_bank();

    // Directed table: reset view, ignored commands, extremes, class order.
    // Timer 3 is hard and already at zero, timer 2 is a soft one-shot, so the
    // first tick after the starts must report timer 3 ahead of timer 2.
    directed_steps.push_back(cmd(OP_TICK, 3'd0, '0, '0, 1'b0));
    directed_steps.push_back(cmd_chk(OP_QUERY, 3'd0, '0, '0, 1'b0,
                                     K_QUERY, ST_UNUSED, '0, '0, 1'b0));
    directed_steps.push_back(cmd_chk(OP_START, 3'd1, '0, '0, 1'b0,
                                     K_IGNORE, ST_UNUSED, '0, '0, 1'b0));
    directed_steps.push_back(cmd_chk(OP_STOP, 3'd1, '0, '0, 1'b0,
                                     K_IGNORE, ST_UNUSED, '0, '0, 1'b0));
    directed_steps.push_back(cmd_chk(OP_RSVD6, 3'd2, '0, '0, 1'b0,
                                     K_IGNORE, ST_UNUSED, '0, '0, 1'b0));
    directed_steps.push_back(cmd_chk(OP_RSVD7, 3'd7, '1, '1, 1'b1,
                                     K_IGNORE, ST_UNUSED, '0, '0, 1'b0));
    directed_steps.push_back(cmd_chk(OP_INIT, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                     K_ACCEPT, ST_CREATED, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 1'b1));
    directed_steps.push_back(cmd_chk(OP_INIT, 3'd1, 32'd0, 32'd3, 1'b0,
                                     K_ACCEPT, ST_CREATED, 32'd3, 32'd0, 1'b0));
    directed_steps.push_back(cmd_chk(OP_INIT, 3'd2, 32'd1, 32'd0, 1'b0,
                                     K_ACCEPT, ST_CREATED, 32'd1, 32'd1, 1'b0));
    directed_steps.push_back(cmd_chk(OP_INIT, 3'd3, 32'd0, 32'd0, 1'b1,
                                     K_ACCEPT, ST_CREATED, 32'd0, 32'd0, 1'b1));
    directed_steps.push_back(cmd_chk(OP_INIT, 3'd7, 32'd2, 32'd1, 1'b0,
                                     K_ACCEPT, ST_CREATED, 32'd2, 32'd2, 1'b0));
    directed_steps.push_back(cmd(OP_START, 3'd0, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_START, 3'd1, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_START, 3'd2, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_START, 3'd3, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_START, 3'd7, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_TICK, 3'd5, '1, '1, 1'b1));
    directed_steps.push_back(cmd(OP_TICK, 3'd0, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_STOP, 3'd0, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_STOP, 3'd0, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_START, 3'd2, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_DESTROY, 3'd1, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_START, 3'd1, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_QUERY, 3'd7, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_TICK, 3'd0, '0, '0, 1'b0));
    directed_steps.push_back(cmd(OP_INIT, 3'd5, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 1'b1));

    // Hold reset, then release it away from the rising edge
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i]) issue(directed_steps[i]);

    // Pause the request side until the block has answered everything
    wait_drained();

    // Random part: mostly init, start and a few ticks on one timer, with
    // random payload on every field; the rest is arbitrary opcodes.
    while (requests_sent < RequestTotal) begin
      if ($urandom_range(0, 9) < 7) begin
        t = IdxW'($urandom_range(0, TimerCount - 1));
        issue(cmd(OP_INIT, t, pick_count(), pick_count(), 1'($urandom_range(0, 1))));
        issue(cmd(OP_START, t, $urandom, $urandom, 1'($urandom_range(0, 1))));
        repeat ($urandom_range(1, 4)) begin
          issue(cmd(OP_TICK, IdxW'($urandom_range(0, 7)), $urandom, $urandom,
                    1'($urandom_range(0, 1))));
        end
      end else begin
        issue(cmd(OpW'($urandom_range(0, 7)), IdxW'($urandom_range(0, 7)), pick_count(),
                  pick_count(), 1'($urandom_range(0, 1))));
      end
    end

    // Drain, then allow a full tick sweep for any result still in flight
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[one_shot_periodic_timer_bank] OK");
    end else begin
      $display("[one_shot_periodic_timer_bank] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall in random bursts; once, hold off long enough to back up the block
  initial begin
    int unsigned hold_left;
    bit          long_hold_done;
    hold_left      = 0;
    long_hold_done = 1'b0;
    out_stall_i    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
      end else if (!calm_tail && !long_hold_done && results_seen >= LongHoldAt) begin
        long_hold_done = 1'b1;
        hold_left      = LongHoldLen;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 9);
      end
      out_stall_i <= (hold_left != 0);
    end
  end

  function automatic bit field_ok(string name, logic [DataW-1:0] want,
                                  logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Match one accepted result against the oldest owed one
  task automatic check_result(input res_t got);
    res_t want;
    bit   ok;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result, kind %0d timer %0d", $time, got.kind, got.which);
      mismatch_count++;
    end else begin
      want = awaited_results.pop_front();
      ok = field_ok("kind", DataW'(want.kind), DataW'(got.kind))
         & field_ok("which_timer", DataW'(want.which), DataW'(got.which))
         & field_ok("life_state", DataW'(want.life), DataW'(got.life))
         & field_ok("remaining", want.remaining, got.remaining)
         & field_ok("delay_out", want.delay, got.delay)
         & field_ok("class_out", DataW'(want.cls), DataW'(got.cls))
         & field_ok("last", DataW'(want.last), DataW'(got.last));
      if (!ok) mismatch_count++;
    end
  endtask

  initial begin
    results_seen   = 0;
    mismatch_count = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      check_result(result_bus);
    end
  end

  // Give up well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[one_shot_periodic_timer_bank] ERROR");
    $finish;
  end

endmodule
